[sv/bpdt_pkg.sv]
// Shared types and constants of the blocked process delay table.
package bpdt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int ID_W   = 16;
    localparam int TICK_W = 8;
    localparam int WAIT_W = 16;
    localparam int OCC_W  = 7;

    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

    // One table entry as stored in memory
    typedef struct packed {
        logic [ID_W-1:0]   ident;
        logic [TICK_W-1:0] countdown;
        logic [WAIT_W-1:0] waited;
    } entry_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;   // capture the word and open a sweep
        logic sweep;   // step the sweep
        logic load;    // commit the tick and load the result register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic sweep_done;
    } dp_sts_t;

    // Wait count plus a small bump, saturating at the field maximum
    function automatic logic [WAIT_W-1:0] wait_add(input logic [WAIT_W-1:0] w,
                                                   input logic [1:0] bump);
        logic [WAIT_W:0] sum;
        sum = {1'b0, w} + {{(WAIT_W-1){1'b0}}, bump};
        return sum[WAIT_W] ? WAIT_MAX : sum[WAIT_W-1:0];
    endfunction

endpackage

[sv/blocked_process_delay_table.sv]
// Top level of the blocked process delay table.
//
// Each input word is one scheduler tick and may carry an arriving blocked
// process, which is appended to an ordered table of TABLE_DEPTH entries or
// reported as dropped when the table is full. Every tick ages all entries
// (countdown down to zero, wait counts raised and saturated), releases the
// first entry whose countdown is zero and closes the gap behind it; exactly
// one result word comes out per tick. A tick is accepted, then swept over the
// entries held plus the arrival, and then loaded into the result register.
// The load waits further while the previous result word is still held. The
// entries live in a single-port read, single-port write memory, and one
// sweep reads, ages and writes back one entry per cycle through a registered
// read and a write-back. Entries are never read before they are written, so
// the memory needs no clearing after reset. The next tick is accepted while
// a result word still waits to be taken.
module blocked_process_delay_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          arrival_valid,
    input  logic [bpdt_pkg::ID_W-1:0]     process_id,
    input  logic [bpdt_pkg::TICK_W-1:0]   block_ticks,
    input  logic [bpdt_pkg::WAIT_W-1:0]   wait_so_far,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          released_valid,
    output logic [bpdt_pkg::ID_W-1:0]     released_id,
    output logic [bpdt_pkg::WAIT_W-1:0]   released_wait,
    output logic [bpdt_pkg::OCC_W-1:0]    occupancy,
    output logic                          arrival_dropped
);

    bpdt_pkg::dp_cmd_t cmd;
    bpdt_pkg::dp_sts_t sts;

    // Sequencing
    bpdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Table and result datapath
    bpdt_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .arrival_valid   (arrival_valid),
        .process_id      (process_id),
        .block_ticks     (block_ticks),
        .wait_so_far     (wait_so_far),
        .released_valid  (released_valid),
        .released_id     (released_id),
        .released_wait   (released_wait),
        .occupancy       (occupancy),
        .arrival_dropped (arrival_dropped)
    );

endmodule

[sv/bpdt_ctrl.sv]
// Controller state machine: handshakes and sequencing of one tick.
module bpdt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output bpdt_pkg::dp_cmd_t cmd,
    input  bpdt_pkg::dp_sts_t sts
);

    bpdt_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    // State and result-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpdt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            bpdt_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = bpdt_pkg::ST_SWEEP;
                end
            end
            bpdt_pkg::ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_done)
                    state_next = bpdt_pkg::ST_FINISH;
            end
            bpdt_pkg::ST_FINISH:
            begin
                // result register free or emptied this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load   = 1'b1;
                    state_next = bpdt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bpdt_pkg::ST_IDLE;
            end
        endcase
    end

    // Result word held until taken
    always_comb
    begin
        if (cmd.load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    assign out_valid = out_valid_reg;

endmodule

[sv/bpdt_datapath.sv]
// Datapath: entry memory, sweep pipeline, release search and result register.
module bpdt_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpdt_pkg::dp_cmd_t             cmd,
    output bpdt_pkg::dp_sts_t             sts,
    input  logic                          arrival_valid,
    input  logic [bpdt_pkg::ID_W-1:0]     process_id,
    input  logic [bpdt_pkg::TICK_W-1:0]   block_ticks,
    input  logic [bpdt_pkg::WAIT_W-1:0]   wait_so_far,
    output logic                          released_valid,
    output logic [bpdt_pkg::ID_W-1:0]     released_id,
    output logic [bpdt_pkg::WAIT_W-1:0]   released_wait,
    output logic [bpdt_pkg::OCC_W-1:0]    occupancy,
    output logic                          arrival_dropped
);

    // Entry memory, one write and one registered read per cycle
    bpdt_pkg::entry_t mem [bpdt_pkg::TABLE_DEPTH];
    bpdt_pkg::entry_t mem_rd_reg;
    logic                          mem_we;
    logic [bpdt_pkg::IDX_W-1:0]    mem_wa;
    bpdt_pkg::entry_t              mem_wd;
    logic                          mem_re;

    // Control state of the sweep
    logic [bpdt_pkg::CNT_W-1:0] count_reg, count_next;
    logic [bpdt_pkg::CNT_W-1:0] n_reg, n_next;
    logic [bpdt_pkg::CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic                       s_valid_reg, s_valid_next;
    logic                       s_from_arr_reg, s_from_arr_next;
    logic [bpdt_pkg::IDX_W-1:0] s_idx_reg, s_idx_next;
    logic                       found_reg, found_next;

    // Captured arrival word
    bpdt_pkg::entry_t arr_reg, arr_next;
    logic             bump2_reg, bump2_next;
    logic             dropped_reg, dropped_next;

    // Released entry
    logic [bpdt_pkg::ID_W-1:0]   rel_id_reg, rel_id_next;
    logic [bpdt_pkg::WAIT_W-1:0] rel_wait_reg, rel_wait_next;

    // Stage arithmetic
    bpdt_pkg::entry_t            s_data;
    bpdt_pkg::entry_t            s_upd;
    logic                        append;
    logic [1:0]                  bump;

    assign append = arrival_valid &&
                    (count_reg < bpdt_pkg::CNT_W'(bpdt_pkg::TABLE_DEPTH));
    assign bump   = bump2_reg ? 2'd2 : 2'd1;
    assign s_data = s_from_arr_reg ? arr_reg : mem_rd_reg;

    // Entry after one tick: countdown down to zero, wait raised
    always_comb
    begin
        s_upd.ident     = s_data.ident;
        s_upd.countdown = (s_data.countdown != '0) ?
                          s_data.countdown - bpdt_pkg::TICK_W'(1) : '0;
        s_upd.waited    = bpdt_pkg::wait_add(s_data.waited, bump);
    end

    assign sts.sweep_done = (rd_idx_reg == n_reg) && !s_valid_reg;

    // Sweep sequencing, release search and compaction
    always_comb
    begin
        count_next      = count_reg;
        n_next          = n_reg;
        rd_idx_next     = rd_idx_reg;
        s_valid_next    = 1'b0;
        s_from_arr_next = 1'b0;
        s_idx_next      = s_idx_reg;
        found_next      = found_reg;
        arr_next        = arr_reg;
        bump2_next      = bump2_reg;
        dropped_next    = dropped_reg;
        rel_id_next     = rel_id_reg;
        rel_wait_next   = rel_wait_reg;
        mem_we          = 1'b0;
        mem_wa          = s_idx_reg;
        mem_wd          = s_upd;
        mem_re          = 1'b0;

        if (cmd.start)
        begin
            arr_next.ident     = process_id;
            arr_next.countdown = block_ticks;
            arr_next.waited    = wait_so_far;
            bump2_next         = arrival_valid;
            dropped_next       = arrival_valid && !append;
            n_next             = append ? count_reg + bpdt_pkg::CNT_W'(1) : count_reg;
            rd_idx_next        = '0;
            found_next         = 1'b0;
            rel_id_next        = '0;
            rel_wait_next      = '0;
        end
        else if (cmd.sweep)
        begin
            // issue the next entry: from memory, or the appended arrival
            if (rd_idx_reg != n_reg)
            begin
                s_valid_next    = 1'b1;
                s_idx_next      = rd_idx_reg[bpdt_pkg::IDX_W-1:0];
                s_from_arr_next = (rd_idx_reg == count_reg);
                mem_re          = (rd_idx_reg != count_reg);
                rd_idx_next     = rd_idx_reg + bpdt_pkg::CNT_W'(1);
            end
            // retire the staged entry
            if (s_valid_reg)
            begin
                if (!found_reg && (s_upd.countdown == '0))
                begin
                    found_next    = 1'b1;
                    rel_id_next   = s_upd.ident;
                    rel_wait_next = s_upd.waited;
                end
                else
                begin
                    mem_we = 1'b1;
                    mem_wa = found_reg ? s_idx_reg - bpdt_pkg::IDX_W'(1) : s_idx_reg;
                end
            end
        end

        if (cmd.load)
            count_next = found_reg ? n_reg - bpdt_pkg::CNT_W'(1) : n_reg;
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            mem_rd_reg <= mem[rd_idx_reg[bpdt_pkg::IDX_W-1:0]];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            n_reg          <= '0;
            rd_idx_reg     <= '0;
            s_valid_reg    <= 1'b0;
            s_from_arr_reg <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            n_reg          <= n_next;
            rd_idx_reg     <= rd_idx_next;
            s_valid_reg    <= s_valid_next;
            s_from_arr_reg <= s_from_arr_next;
            found_reg      <= found_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s_idx_reg    <= s_idx_next;
        arr_reg      <= arr_next;
        bump2_reg    <= bump2_next;
        dropped_reg  <= dropped_next;
        rel_id_reg   <= rel_id_next;
        rel_wait_reg <= rel_wait_next;
        if (cmd.load)
        begin
            released_valid  <= found_reg;
            released_id     <= rel_id_reg;
            released_wait   <= rel_wait_reg;
            occupancy       <= bpdt_pkg::OCC_W'(count_next);
            arrival_dropped <= dropped_reg;
        end
    end

endmodule

[tb/blocked_process_delay_table_test.sv]
// Self-checking testbench for the blocked process delay table: random ticks, predicted results.
`timescale 1ns / 1ps

module blocked_process_delay_table_test;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int ITEMS_PHASE   = 350;
    localparam int DRAIN_CYCLES  = 100;
    localparam int HOLDOFF_LEN   = 400;
    localparam int HOLDOFF_AFTER = 60;

    // One tick word as offered to the block
    typedef struct packed {
        logic                        arrive;
        logic [bpdt_pkg::ID_W-1:0]   id;
        logic [bpdt_pkg::TICK_W-1:0] blk;
        logic [bpdt_pkg::WAIT_W-1:0] wso;
    } tick_word_t;

    // One result word as it leaves the block
    typedef struct packed {
        logic                        rel_valid;
        logic [bpdt_pkg::ID_W-1:0]   rel_id;
        logic [bpdt_pkg::WAIT_W-1:0] rel_wait;
        logic [bpdt_pkg::OCC_W-1:0]  occ;
        logic                        dropped;
    } release_word_t;

    // Kinds of random word sequences
    typedef enum int {
        SEQ_FILL,
        SEQ_MIXED,
        SEQ_QUIET,
        SEQ_SATURATE
    } seq_kind_t;

    logic                        clk;
    logic                        rst_n           = 1'b0;
    logic                        in_valid        = 1'b0;
    logic                        in_stall;
    logic                        arrival_valid   = 1'b0;
    logic [bpdt_pkg::ID_W-1:0]   process_id      = '0;
    logic [bpdt_pkg::TICK_W-1:0] block_ticks     = '0;
    logic [bpdt_pkg::WAIT_W-1:0] wait_so_far     = '0;
    logic                        out_valid;
    logic                        out_stall       = 1'b0;
    logic                        released_valid;
    logic [bpdt_pkg::ID_W-1:0]   released_id;
    logic [bpdt_pkg::WAIT_W-1:0] released_wait;
    logic [bpdt_pkg::OCC_W-1:0]  occupancy;
    logic                        arrival_dropped;

    tick_word_t    pending_ticks[$];
    release_word_t expected_releases[$];

    // Predicted table contents
    logic [bpdt_pkg::ID_W-1:0]   tbl_ident[bpdt_pkg::TABLE_DEPTH];
    logic [bpdt_pkg::TICK_W-1:0] tbl_countdown[bpdt_pkg::TABLE_DEPTH];
    logic [bpdt_pkg::WAIT_W-1:0] tbl_waited[bpdt_pkg::TABLE_DEPTH];
    int                          tbl_count = 0;

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int errors          = 0;
    int results_seen    = 0;
    int cycle_count     = 0;
    int holdoff_left    = 0;
    bit holdoff_used    = 1'b0;

    blocked_process_delay_table DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .arrival_valid   (arrival_valid),
        .process_id      (process_id),
        .block_ticks     (block_ticks),
        .wait_so_far     (wait_so_far),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .released_valid  (released_valid),
        .released_id     (released_id),
        .released_wait   (released_wait),
        .occupancy       (occupancy),
        .arrival_dropped (arrival_dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Saturating wait increment
    function automatic logic [bpdt_pkg::WAIT_W-1:0] wait_inc(
        input logic [bpdt_pkg::WAIT_W-1:0] w);
        return (w == '1) ? w : w + 1'b1;
    endfunction

    // Advance the predicted table by one tick and return the release it causes
    function automatic release_word_t tick_table(input tick_word_t w);
        release_word_t r;
        int hit;
        r   = '0;
        hit = -1;
        if (w.arrive)
        begin
            if (tbl_count < bpdt_pkg::TABLE_DEPTH)
            begin
                tbl_ident[tbl_count]     = w.id;
                tbl_countdown[tbl_count] = w.blk;
                tbl_waited[tbl_count]    = w.wso;
                tbl_count++;
            end
            else
                r.dropped = 1'b1;
            for (int i = 0; i < tbl_count; i++)
                tbl_waited[i] = wait_inc(tbl_waited[i]);
        end
        // age all entries, find the first expired one
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_countdown[i] != 0)
                tbl_countdown[i] = tbl_countdown[i] - 1'b1;
            tbl_waited[i] = wait_inc(tbl_waited[i]);
            if (hit < 0 && tbl_countdown[i] == 0)
                hit = i;
        end
        // release and close the gap
        if (hit >= 0)
        begin
            r.rel_valid = 1'b1;
            r.rel_id    = tbl_ident[hit];
            r.rel_wait  = tbl_waited[hit];
            for (int i = hit; i + 1 < tbl_count; i++)
            begin
                tbl_ident[i]     = tbl_ident[i + 1];
                tbl_countdown[i] = tbl_countdown[i + 1];
                tbl_waited[i]    = tbl_waited[i + 1];
            end
            tbl_count--;
        end
        r.occ = tbl_count[bpdt_pkg::OCC_W-1:0];
        return r;
    endfunction

    function automatic tick_word_t make_word(input logic arrive, input int blk_lo,
                                             input int blk_hi, input bit near_sat);
        tick_word_t w;
        w.arrive = arrive;
        w.id     = bpdt_pkg::ID_W'($urandom_range(16'hFFFF, 0));
        w.blk    = bpdt_pkg::TICK_W'($urandom_range(blk_hi, blk_lo));
        w.wso    = near_sat ? bpdt_pkg::WAIT_W'($urandom_range(16'hFFFF, 16'hFFFA))
                            : bpdt_pkg::WAIT_W'($urandom_range(16'hFFFF, 0));
        return w;
    endfunction

    task automatic push_word(input logic arrive, input logic [bpdt_pkg::ID_W-1:0] id,
                             input logic [bpdt_pkg::TICK_W-1:0] blk,
                             input logic [bpdt_pkg::WAIT_W-1:0] wso);
        tick_word_t w;
        w = '{arrive, id, blk, wso};
        pending_ticks.push_back(w);
    endtask

    task automatic push_sequence(input seq_kind_t kind);
        case (kind)
            // arrivals with long block times until the table overflows
            SEQ_FILL:
                for (int i = 0; i < 75; i++)
                    pending_ticks.push_back(make_word(1'b1, 120, 255, 1'b0));
            SEQ_MIXED:
                for (int i = 0; i < 30; i++)
                    if ($urandom_range(3) == 0)
                        pending_ticks.push_back(
                            make_word(1'($urandom_range(1)), 0, 255, 1'b0));
                    else
                        pending_ticks.push_back(
                            make_word(1'($urandom_range(1)), 0, 12, 1'b0));
            // ticks with no arrival, payload is noise
            SEQ_QUIET:
                for (int i = 0; i < 25; i++)
                    pending_ticks.push_back(make_word(1'b0, 0, 255, 1'b0));
            SEQ_SATURATE:
                for (int i = 0; i < 15; i++)
                    pending_ticks.push_back(make_word(1'b1, 0, 5, 1'b1));
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Sender: offer words from the pending queue, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        tick_word_t nxt;
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            arrival_valid <= 1'b0;
            process_id    <= '0;
            block_ticks   <= '0;
            wait_so_far   <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_releases.push_back(
                    tick_table('{arrival_valid, process_id, block_ticks, wait_so_far}));
            if (!in_valid || !in_stall)
            begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    nxt           = pending_ticks.pop_front();
                    in_valid      <= 1'b1;
                    arrival_valid <= nxt.arrive;
                    process_id    <= nxt.id;
                    block_ticks   <= nxt.blk;
                    wait_so_far   <= nxt.wso;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, once, after HOLDOFF_AFTER result words have been seen
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_left <= 0;
            holdoff_used <= 1'b0;
        end
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
        else if (!holdoff_used && results_seen >= HOLDOFF_AFTER)
        begin
            holdoff_left <= HOLDOFF_LEN;
            holdoff_used <= 1'b1;
        end
    end

    // Receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= (holdoff_left != 0) || ($urandom_range(99) < stall_pct);
    end

    // Monitor: compare each accepted result word with the oldest prediction
    always @(posedge clk)
    begin : monitor_proc
        release_word_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen <= results_seen + 1;
            if (expected_releases.size() == 0)
            begin
                $display("%0t: result word with nothing expected, actual %h %h %h %h %h",
                         $time, released_valid, released_id, released_wait,
                         occupancy, arrival_dropped);
                errors++;
            end
            else
            begin
                exp_r = expected_releases.pop_front();
                check_field("released_valid", exp_r.rel_valid, released_valid);
                check_field("released_id", exp_r.rel_id, released_id);
                check_field("released_wait", exp_r.rel_wait, released_wait);
                check_field("occupancy", exp_r.occ, occupancy);
                check_field("arrival_dropped", exp_r.dropped, arrival_dropped);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin : stim_proc
        int sent;
        int sender_tbl[4];
        int stall_tbl[4];
        sender_tbl = '{0, 87, 0, 30};
        stall_tbl  = '{0, 0, 87, 30};

        // directed ticks: extremes, zero block time, saturation, ordering
        push_word(1'b0, 16'hFFFF, 8'hFF, 16'hFFFF);   // empty table, no release
        push_word(1'b1, 16'hFFFF, 8'h00, 16'h0000);   // released in its arrival tick
        push_word(1'b1, 16'h0000, 8'hFF, 16'hFFFF);   // saturated from the start
        push_word(1'b1, 16'h1234, 8'h01, 16'hFFFE);   // saturates during the tick
        push_word(1'b1, 16'h4321, 8'h02, 16'hFFFD);
        push_word(1'b0, 16'h0000, 8'h00, 16'h0000);
        push_word(1'b0, 16'hAAAA, 8'h55, 16'h5555);
        push_word(1'b1, 16'h5A5A, 8'h03, 16'h0001);
        push_word(1'b1, 16'hA5A5, 8'h01, 16'h8000);   // released in its arrival tick
        push_word(1'b1, 16'h0F0F, 8'h00, 16'h7FFF);
        push_word(1'b1, 16'hFFFF, 8'hFF, 16'hFFFF);
        push_word(1'b1, 16'h0000, 8'h00, 16'hFFFF);
        push_word(1'b0, 16'h5555, 8'hAA, 16'hAAAA);
        push_word(1'b0, 16'hFFFF, 8'h00, 16'h0000);
        push_word(1'b1, 16'h8001, 8'h80, 16'h0000);
        push_word(1'b1, 16'h7FFE, 8'h7F, 16'hFFFF);
        push_word(1'b0, 16'h0000, 8'hFF, 16'h0000);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // idling phases
        for (int ph = 0; ph < 4; ph++)
        begin
            sender_idle_pct <= sender_tbl[ph];
            stall_pct       <= stall_tbl[ph];
            sent = pending_ticks.size();
            push_sequence(SEQ_FILL);
            while (pending_ticks.size() - sent < ITEMS_PHASE)
                push_sequence(seq_kind_t'($urandom_range(3)));
            while (pending_ticks.size() != 0)
                @(posedge clk);
        end

        while (in_valid || pending_ticks.size() != 0)
            @(posedge clk);
        while (expected_releases.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
